// File: src/lts_pkg.sv
`timescale 1ns / 1ps
package lts_pkg;
  localparam int TAG_W = 14;
  localparam int OWN_W = 3;
  localparam logic [OWN_W-1:0] NO_OWNER = 3'd4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_PROBE  = 2'd1,
    OP_REPL   = 2'd2,
    OP_INVAL  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_MAX_USE = 3'd0,
    CFG_PART_EN = 3'd1,
    CFG_QUOTA0  = 3'd2,
    CFG_QUOTA1  = 3'd3,
    CFG_QUOTA2  = 3'd4,
    CFG_QUOTA3  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             touched;
    logic [OWN_W-1:0] owner;
  } line_t;

  typedef struct packed {
    logic             hit;
    logic [3:0]       hit_depth;
    logic             victim_valid;
    logic [TAG_W-1:0] victim_tag;
    logic [OWN_W-1:0] victim_owner;
    logic             interference;
    logic             no_victim;
  } result_t;

  typedef struct packed {
    logic [4:0] max_use_ways;
    logic       partition_enable;
    logic [4:0] quota0;
    logic [4:0] quota1;
    logic [4:0] quota2;
    logic [4:0] quota3;
  } cfg_t;
endpackage

// File: src/lts_if.sv
`timescale 1ns / 1ps
interface lts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] addr;
  logic [1:0]  cpu_id;
  modport source (output valid, op, addr, cpu_id, input ready);
  modport sink (input valid, op, addr, cpu_id, output ready);
endinterface

interface lts_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [3:0]  hit_depth;
  logic        victim_valid;
  logic [13:0] victim_tag;
  logic [2:0]  victim_owner;
  logic        interference;
  logic        no_victim;
  modport source (output valid, hit, hit_depth, victim_valid, victim_tag, victim_owner,
                  interference, no_victim, input ready);
  modport sink (input valid, hit, hit_depth, victim_valid, victim_tag, victim_owner,
                interference, no_victim, output ready);
endinterface

// File: src/lru_tag_store_way_partitioned.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload
// in_       in   op, addr, cpu_id
// out_      out  hit, hit_depth, victim_valid, victim_tag, victim_owner,
//                interference, no_victim
// cfg_      in   we, idx, data
// A new beat is taken only in IDLE, once the last is through: set row read at accept,
// then compare/reorder, write back and result register in READ. The set row RAM read is registered.
// After reset a clearing pass writes every set row, and no input is taken meanwhile.
// A stalled result holds; a new beat is taken only once the result register is empty
// or being taken in the same cycle.
module lru_tag_store_way_partitioned
  import lts_pkg::*;
#(
  parameter int WAYS = 16,
  parameter int SETS = 1024,
  parameter int BLOCK_BYTES = 64,
  parameter int BANKS = 4,
  parameter int CORES = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lts_in_if.sink                in_ch,
  lts_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SET_SHIFT = $clog2(BLOCK_BYTES) + $clog2(BANKS);
  localparam int TAG_SHIFT = SET_SHIFT + $clog2(SETS);
  localparam int LW = $bits(line_t);
  localparam int RW = LW * WAYS;

  state_t state_r, state_nxt;
  cfg_t   cfg_r;
  logic [SW-1:0] clr_r;
  op_t           op_r;
  logic [SW-1:0] set_r;
  logic [TAG_W-1:0] tag_r;
  logic [1:0]    me_r;
  result_t       res_r, res_c;
  logic          ovalid_r;

  logic [RW-1:0] rdata, wdata;
  logic [SW-1:0] waddr, raddr;
  logic          we, row_we;
  line_t         row_in [WAYS];
  line_t         row_out [WAYS];
  line_t         clr_line;
  logic          accept;
  logic [1:0]    me_in;
  logic [63:0]   addr_x;

  assign addr_x = {32'd0, in_ch.addr};
  assign accept = in_ch.valid && in_ch.ready;
  assign me_in = (32'(in_ch.cpu_id) >= CORES) ? 2'(CORES - 1) : in_ch.cpu_id;

  always_comb begin
    clr_line = '0;
    clr_line.owner = NO_OWNER;
    for (int i = 0; i < WAYS; i++) begin
      row_in[i] = rdata[i*LW +: LW];
      wdata[i*LW +: LW] = (state_r == ST_CLEAR) ? clr_line : row_out[i];
    end
  end

  assign raddr = (SETS > 1) ? SW'(addr_x >> SET_SHIFT) : '0;
  assign waddr = (state_r == ST_CLEAR) ? clr_r : set_r;
  assign we = (state_r == ST_CLEAR) || (state_r == ST_READ && row_we);

  lts_ram #(.WIDTH(RW), .DEPTH(SETS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  lts_row_update #(.WAYS(WAYS)) u_upd (
    .row_in(row_in), .op(op_r), .tag(tag_r), .me(me_r), .cfg(cfg_r),
    .row_out(row_out), .row_we(row_we), .res(res_c)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (32'(clr_r) == SETS - 1) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == ST_IDLE) && (!ovalid_r || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      ovalid_r <= 1'b0;
      cfg_r.max_use_ways <= 5'd16;
      cfg_r.partition_enable <= 1'b0;
      cfg_r.quota0 <= 5'd4;
      cfg_r.quota1 <= 5'd4;
      cfg_r.quota2 <= 5'd4;
      cfg_r.quota3 <= 5'd4;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + SW'(1);
      if (state_r == ST_READ) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_MAX_USE: cfg_r.max_use_ways <= cfg_data;
          CFG_PART_EN: cfg_r.partition_enable <= cfg_data[0];
          CFG_QUOTA0:  cfg_r.quota0 <= cfg_data;
          CFG_QUOTA1:  cfg_r.quota1 <= cfg_data;
          CFG_QUOTA2:  cfg_r.quota2 <= cfg_data;
          CFG_QUOTA3:  cfg_r.quota3 <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_t'(in_ch.op);
      set_r <= raddr;
      tag_r <= TAG_W'(addr_x >> TAG_SHIFT);
      me_r <= me_in;
    end
    if (state_r == ST_READ) res_r <= res_c;
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.hit = res_r.hit;
  assign out_ch.hit_depth = res_r.hit_depth;
  assign out_ch.victim_valid = res_r.victim_valid;
  assign out_ch.victim_tag = res_r.victim_tag;
  assign out_ch.victim_owner = res_r.victim_owner;
  assign out_ch.interference = res_r.interference;
  assign out_ch.no_victim = res_r.no_victim;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_ch.ready |-> !accept) else $error("accept while result pending");
  a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> ovalid_r) else $error("result missing");
  a_nv_fill: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ && res_c.no_victim |-> !we) else $error("fill without victim");
  a_no_clr_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ch.ready) else $error("ready during clear");
endmodule

// File: src/lts_ram.sv
`timescale 1ns / 1ps
module lts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/lts_row_update.sv
`timescale 1ns / 1ps
module lts_row_update
  import lts_pkg::*;
#(
  parameter int WAYS = 16
) (
  input  line_t            row_in [WAYS],
  input  op_t              op,
  input  logic [TAG_W-1:0] tag,
  input  logic [1:0]       me,
  input  cfg_t             cfg,
  output line_t            row_out [WAYS],
  output logic             row_we,
  output result_t          res
);
  localparam int PW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW = $clog2(WAYS + 1);

  logic [CW-1:0]  usable;
  logic [WAYS-1:0] match, owned_me, over_q, mine_m, over_m;
  logic [CW-1:0]  cnt [4];
  logic [4:0]     quota [4];
  logic           found, search_hit, vic_ok, move, is_repl;
  logic [PW-1:0]  hpos, vpos, pos;
  logic [CW-1:0]  vpos_w;
  line_t          vline;

  always_comb begin
    if (cfg.max_use_ways == 5'd0) begin
      usable = CW'(1);
    end else if (32'(cfg.max_use_ways) > WAYS) begin
      usable = CW'(WAYS);
    end else begin
      usable = CW'(cfg.max_use_ways);
    end
    quota[0] = cfg.quota0;
    quota[1] = cfg.quota1;
    quota[2] = cfg.quota2;
    quota[3] = cfg.quota3;
  end

  always_comb begin
    found = 1'b0;
    hpos = '0;
    for (int i = 0; i < WAYS; i++) begin
      match[i] = row_in[i].valid && (row_in[i].tag == tag);
      if (match[i] && !found) begin
        found = 1'b1;
        hpos = PW'(i);
      end
    end
    search_hit = found && (CW'(hpos) < usable);
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      cnt[c] = '0;
    end
    for (int i = 0; i < WAYS; i++) begin
      for (int c = 0; c < 4; c++) begin
        if (row_in[i].owner == OWN_W'(c)) begin
          cnt[c] = cnt[c] + CW'(1);
        end
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      owned_me[i] = (row_in[i].owner == {1'b0, me});
      over_q[i] = (row_in[i].owner < NO_OWNER) &&
                  (6'(cnt[row_in[i].owner[1:0]]) > 6'(quota[row_in[i].owner[1:0]]));
    end
  end

  always_comb begin
    logic f1, f2;
    f1 = 1'b0;
    f2 = 1'b0;
    mine_m = '0;
    over_m = '0;
    vpos = '0;
    vic_ok = 1'b1;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (owned_me[i] && !f1) begin
        f1 = 1'b1;
        mine_m[i] = 1'b1;
      end
      if (over_q[i] && !f2) begin
        f2 = 1'b1;
        over_m[i] = 1'b1;
      end
    end
    if (!cfg.partition_enable) begin
      vpos_w = usable - CW'(1);
      vpos = vpos_w[PW-1:0];
    end else if (6'(cnt[me]) < 6'(quota[me])) begin
      if (!row_in[WAYS-1].touched) begin
        vpos = PW'(WAYS - 1);
      end else begin
        vic_ok = f2;
        for (int i = 0; i < WAYS; i++) begin
          if (over_m[i]) vpos = PW'(i);
        end
      end
    end else begin
      vic_ok = f1;
      for (int i = 0; i < WAYS; i++) begin
        if (mine_m[i]) vpos = PW'(i);
      end
    end
    if (cfg.partition_enable) begin
      vpos_w = '0;
    end else begin
      vpos_w = usable - CW'(1);
    end
  end

  always_comb begin
    is_repl = (op == OP_REPL);
    vline = row_in[vpos];
    pos = is_repl ? vpos : hpos;
    move = is_repl ? vic_ok : (search_hit && op == OP_LOOKUP);
    row_we = move || (search_hit && op == OP_INVAL);
    for (int i = 0; i < WAYS; i++) begin
      row_out[i] = row_in[i];
      if (move && PW'(i) <= pos && i > 0) begin
        row_out[i] = row_in[i-1];
      end
    end
    if (move) begin
      row_out[0] = row_in[pos];
      if (is_repl) begin
        row_out[0].tag = tag;
        row_out[0].valid = 1'b1;
        row_out[0].touched = 1'b1;
        row_out[0].owner = {1'b0, me};
      end
    end else if (search_hit && op == OP_INVAL) begin
      row_out[hpos].valid = 1'b0;
      row_out[hpos].touched = 1'b0;
    end

    res = '0;
    res.victim_owner = NO_OWNER;
    if (is_repl) begin
      if (!vic_ok) begin
        res.no_victim = 1'b1;
      end else begin
        res.victim_valid = vline.valid;
        res.victim_tag = vline.valid ? vline.tag : '0;
        res.victim_owner = vline.owner;
        res.interference = (vline.owner != NO_OWNER) && (vline.owner != {1'b0, me});
      end
    end else if (search_hit) begin
      res.hit = 1'b1;
      res.hit_depth = 4'(hpos);
    end
  end
endmodule
